### hw/rtl/blle_pkg.sv
// Shared types and constants for the bounded linked list engine.
// Holds opcodes, status codes, the controller state type and the result record.
// No dependencies.
package blle_pkg;

  // Default build parameters.
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Request opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_DELETE     = 3'd2,
    OP_SEARCH     = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_POP_BACK   = 3'd5
  } opcode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PUSH_WR,
    S_PUSH_LINK,
    S_POP_FRONT,
    S_WALK,
    S_GIVE,
    S_DONE
  } state_t;

  // One result item as handed from the controller to the output stage.
  typedef struct packed {
    logic                 found;
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } result_t;

endpackage

### hw/rtl/blle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; width and depth come from parameters.
module blle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/blle_outreg.sv
// Output register stage that holds one result until the consumer takes it.
// Depends on blle_pkg for the result record.
module blle_outreg
  import blle_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  result_t            res,
  output logic               res_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count
);

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t res_r;
  logic    load;

  // The register can take a new result when empty or when its content leaves now.
  assign res_stall = out_valid_r && out_stall;
  assign load      = res_valid && !res_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = res_r.found;
  assign out_status = res_r.status;
  assign out_count  = res_r.count;

endmodule

### hw/rtl/blle_ctrl.sv
// Sequencer for the linked list: list pointers, free list, count and the link walk.
// Depends on blle_pkg; drives the value and link RAMs instantiated at the top level.
module blle_ctrl
  import blle_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  // Shared read address for both RAMs.
  output logic [AW-1:0]         mem_raddr,
  // Link RAM.
  output logic                  lk_we,
  output logic [AW-1:0]         lk_waddr,
  output logic [AW-1:0]         lk_wdata,
  input  logic [AW-1:0]         lk_rdata,
  // Value RAM.
  output logic                  vl_we,
  output logic [AW-1:0]         vl_waddr,
  output logic [DATA_WIDTH-1:0] vl_wdata,
  input  logic [DATA_WIDTH-1:0] vl_rdata,
  // Result toward the output stage.
  output logic                  res_valid,
  output result_t               res,
  input  logic                  res_stall
);

  state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] free_r, free_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] init_r, init_nxt;

  // Per-request working registers.
  opcode_t               op_r, op_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]         cur_r, cur_nxt;
  logic [AW-1:0]         prev_r, prev_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic                  found_r, found_nxt;
  status_t               status_r, status_nxt;

  logic [DATA_WIDTH-1:0] vin;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  match;
  logic [CW-1:0]         k_ext;
  opcode_t               in_op;

  // Operand as stored: the low bits of the request value, zero-extended if wider.
  if (DATA_WIDTH <= VALUE_W) begin : g_narrow
    assign vin = in_value[DATA_WIDTH-1:0];
  end else begin : g_wide
    assign vin = {{(DATA_WIDTH - VALUE_W){1'b0}}, in_value};
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_op    = opcode_t'(in_opcode);
  assign full     = (cnt_r == CW'(CAPACITY));
  assign empty    = (cnt_r == '0);
  assign match    = (vl_rdata == val_r);
  assign k_ext    = CW'(k_r);

  // Next state, pointer updates and RAM accesses.
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    free_nxt   = free_r;
    cnt_nxt    = cnt_r;
    init_nxt   = init_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    slot_nxt   = slot_r;
    k_nxt      = k_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    mem_raddr  = cur_r;
    lk_we      = 1'b0;
    lk_waddr   = slot_r;
    lk_wdata   = '0;
    vl_we      = 1'b0;
    vl_waddr   = free_r;
    vl_wdata   = val_r;
    res_valid  = 1'b0;

    unique case (state_r)
      // Chain every slot into the free list, one entry per cycle.
      S_INIT: begin
        lk_we    = 1'b1;
        lk_waddr = init_r;
        if (init_r == AW'(CAPACITY - 1)) begin
          lk_wdata  = '0;
          state_nxt = S_IDLE;
        end else begin
          lk_wdata = init_r + AW'(1);
        end
        init_nxt = init_r + AW'(1);
      end

      // Take a request and start the read that its first step needs.
      S_IDLE: begin
        mem_raddr = head_r;
        if (accept) begin
          op_nxt     = in_op;
          val_nxt    = vin;
          cur_nxt    = head_r;
          k_nxt      = '0;
          found_nxt  = 1'b0;
          status_nxt = ST_DONE;
          state_nxt  = S_DONE;
          unique case (in_op) inside
            OP_APPEND, OP_PREPEND: begin
              mem_raddr = free_r;
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_PUSH_WR;
              end
            end
            OP_DELETE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_WALK;
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                status_nxt = ST_ABSENT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_POP_FRONT;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (cnt_r == CW'(1)) begin
                slot_nxt  = head_r;
                state_nxt = S_GIVE;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              // Unknown opcodes leave the list alone and report done.
            end
          endcase
        end
      end

      // Allocate the free head: the link read has returned its successor.
      S_PUSH_WR: begin
        free_nxt = lk_rdata;
        slot_nxt = free_r;
        vl_we    = 1'b1;
        vl_waddr = free_r;
        vl_wdata = val_r;
        lk_we    = 1'b1;
        lk_waddr = free_r;
        lk_wdata = (op_r == OP_PREPEND && !empty) ? head_r : '0;
        cnt_nxt  = cnt_r + CW'(1);
        if (empty) begin
          head_nxt  = free_r;
          tail_nxt  = free_r;
          state_nxt = S_DONE;
        end else if (op_r == OP_PREPEND) begin
          head_nxt  = free_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PUSH_LINK;
        end
      end

      // Hook the new slot behind the old tail.
      S_PUSH_LINK: begin
        lk_we     = 1'b1;
        lk_waddr  = tail_r;
        lk_wdata  = slot_r;
        tail_nxt  = slot_r;
        state_nxt = S_DONE;
      end

      // Unlink the head and return it to the free list.
      S_POP_FRONT: begin
        head_nxt  = lk_rdata;
        lk_we     = 1'b1;
        lk_waddr  = cur_r;
        lk_wdata  = free_r;
        free_nxt  = cur_r;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_DONE;
      end

      // Follow the links one entry per cycle; RAM data belongs to cur_r.
      S_WALK: begin
        if (op_r == OP_POP_BACK) begin
          if (k_ext == cnt_r - CW'(2)) begin
            // cur_r is the new tail; its successor is the slot to free.
            slot_nxt  = lk_rdata;
            lk_we     = 1'b1;
            lk_waddr  = cur_r;
            lk_wdata  = '0;
            tail_nxt  = cur_r;
            state_nxt = S_GIVE;
          end else begin
            mem_raddr = lk_rdata;
            prev_nxt  = cur_r;
            cur_nxt   = lk_rdata;
            k_nxt     = k_r + AW'(1);
          end
        end else if (match) begin
          found_nxt  = 1'b1;
          status_nxt = ST_DONE;
          if (op_r == OP_DELETE) begin
            slot_nxt = cur_r;
            if (k_r == '0) begin
              head_nxt = lk_rdata;
            end else begin
              lk_we    = 1'b1;
              lk_waddr = prev_r;
              lk_wdata = lk_rdata;
              if (cur_r == tail_r) begin
                tail_nxt = prev_r;
              end
            end
            state_nxt = S_GIVE;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (k_ext == cnt_r - CW'(1)) begin
          status_nxt = ST_ABSENT;
          state_nxt  = S_DONE;
        end else begin
          mem_raddr = lk_rdata;
          prev_nxt  = cur_r;
          cur_nxt   = lk_rdata;
          k_nxt     = k_r + AW'(1);
        end
      end

      // Return slot_r to the front of the free list.
      S_GIVE: begin
        lk_we     = 1'b1;
        lk_waddr  = slot_r;
        lk_wdata  = free_r;
        free_nxt  = slot_r;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_DONE;
      end

      // Hand the result to the output stage.
      S_DONE: begin
        res_valid = 1'b1;
        if (!res_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.found  = found_r;
  assign res.status = status_r;
  assign res.count  = COUNT_W'(cnt_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      free_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    slot_r   <= slot_nxt;
    k_r      <= k_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

endmodule

### hw/rtl/bounded_linked_list_engine_unit.sv
// Bounded linked list engine: value and link RAMs, sequencer and output register.
// Rejects, empty-list cases and unknown opcodes go straight to the result; push back adds a
// link step, and pop back, delete and search walk the links. One request at a time: the next
// is taken once the result of the last has been loaded into the output register. After reset
// the sequencer chains every slot into the free list before it takes a request.
module bounded_linked_list_engine_unit
  import blle_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OPCODE_W-1:0]       in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [STATUS_W-1:0]       out_status,
  output logic [COUNT_W-1:0]        out_count
);

  localparam int AW = $clog2(CAPACITY);

  logic [AW-1:0]         mem_raddr;
  logic                  lk_we;
  logic [AW-1:0]         lk_waddr;
  logic [AW-1:0]         lk_wdata;
  logic [AW-1:0]         lk_rdata;
  logic                  vl_we;
  logic [AW-1:0]         vl_waddr;
  logic [DATA_WIDTH-1:0] vl_wdata;
  logic [DATA_WIDTH-1:0] vl_rdata;
  logic                  res_valid;
  logic                  res_stall;
  result_t               res;

  // Link store: successor slot of every entry, also the free list.
  blle_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (mem_raddr),
    .rdata (lk_rdata)
  );

  // Value store: payload of every allocated slot.
  blle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (vl_wdata),
    .raddr (mem_raddr),
    .rdata (vl_rdata)
  );

  // Sequencer.
  blle_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .mem_raddr (mem_raddr),
    .lk_we     (lk_we),
    .lk_waddr  (lk_waddr),
    .lk_wdata  (lk_wdata),
    .lk_rdata  (lk_rdata),
    .vl_we     (vl_we),
    .vl_waddr  (vl_waddr),
    .vl_wdata  (vl_wdata),
    .vl_rdata  (vl_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_stall (res_stall)
  );

  // Result register toward the consumer.
  blle_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_stall  (res_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_found  (out_found),
    .out_status (out_status),
    .out_count  (out_count)
  );

endmodule
